/* src/dvs_pkg.sv */
`default_nettype none

package dvs_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_MAX_THREADS   = 64;
    localparam int DEF_RES_LIMIT     = 16;
    localparam int DEF_AMOUNT_WIDTH  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int HEUR_W     = 3;
    localparam int THR_CFG_W  = 7;
    localparam int RES_CFG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEURISTIC        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREADS_IN_USE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES_IN_USE = 2'd2;

    localparam logic [THR_CFG_W-1:0] THR_CFG_RESET = 7'd64;
    localparam logic [RES_CFG_W-1:0] RES_CFG_RESET = 5'd16;

    // Selection heuristics
    localparam logic [HEUR_W-1:0] HEUR_MAX_TOTAL    = 3'd0;
    localparam logic [HEUR_W-1:0] HEUR_MIN_TOTAL    = 3'd1;
    localparam logic [HEUR_W-1:0] HEUR_MAX_LARGEST  = 3'd2;
    localparam logic [HEUR_W-1:0] HEUR_MIN_SMALLEST = 3'd3;
    localparam logic [HEUR_W-1:0] HEUR_MAX_COUNT    = 3'd4;
    localparam logic [HEUR_W-1:0] HEUR_MIN_COUNT    = 3'd5;
    localparam logic [HEUR_W-1:0] HEUR_RESET        = HEUR_MAX_TOTAL;

    // Unused codes behave as max total
    function automatic logic want_max(input logic [HEUR_W-1:0] h);
        logic r;
        case (h)
            HEUR_MIN_TOTAL, HEUR_MIN_SMALLEST, HEUR_MIN_COUNT: r = 1'b0;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    // Clamp a configured count into 1..maxv
    function automatic logic [31:0] clamp_count(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/dvs_if.sv */
`default_nettype none

interface dvs_in_if #(
    parameter int AMOUNT_WIDTH = dvs_pkg::DEF_AMOUNT_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic [AMOUNT_WIDTH-1:0] alloc_amount;
    logic                    thread_deadlocked;

    modport source (output valid, output alloc_amount, output thread_deadlocked, input ready);
    modport sink   (input valid, input alloc_amount, input thread_deadlocked, output ready);
endinterface

interface dvs_out_if #(
    parameter int INDEX_WIDTH  = 6,
    parameter int METRIC_WIDTH = 21
);
    logic                           valid;
    logic                           ready;
    logic [INDEX_WIDTH-1:0]         victim_index;
    logic                           victim_found;
    logic signed [METRIC_WIDTH-1:0] victim_metric;

    modport source (output valid, output victim_index, output victim_found,
                    output victim_metric, input ready);
    modport sink   (input valid, input victim_index, input victim_found,
                    input victim_metric, output ready);
endinterface

interface dvs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dvs_pkg::CFG_IDX_W-1:0]   index;
    logic [dvs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/dvs_row_acc.sv */
`default_nettype none

module dvs_row_acc #(
    parameter int RES_LIMIT     = dvs_pkg::DEF_RES_LIMIT,
    parameter int AMOUNT_WIDTH  = dvs_pkg::DEF_AMOUNT_WIDTH
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_accept,
    input  wire  [AMOUNT_WIDTH-1:0]               i_amount,
    input  wire  [dvs_pkg::HEUR_W-1:0]            i_heuristic,
    input  wire  [dvs_pkg::RES_CFG_W-1:0]         i_res_count,
    output logic                                  o_row_last,
    output logic signed [AMOUNT_WIDTH+$clog2(RES_LIMIT):0] o_metric
);

    localparam int SUM_W = AMOUNT_WIDTH + $clog2(RES_LIMIT);
    localparam int MW    = SUM_W + 1;
    localparam int CNT_W = $clog2(RES_LIMIT + 1);
    localparam int EW    = (RES_LIMIT > 1) ? $clog2(RES_LIMIT) : 1;

    logic [EW-1:0]           r_entry, n_entry;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [AMOUNT_WIDTH-1:0] r_largest, n_largest;
    logic [AMOUNT_WIDTH-1:0] r_small, n_small;
    logic                    r_has, n_has;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [31:0]             nres;
    logic                    nz;

    assign nres = dvs_pkg::clamp_count(32'(i_res_count), 32'(RES_LIMIT));
    assign nz   = (i_amount != '0);

    always_comb begin
        o_row_last = (32'(r_entry) + 32'd1 >= nres);
        n_sum      = r_sum + SUM_W'(i_amount);
        n_largest  = (i_amount > r_largest) ? i_amount : r_largest;
        n_small    = r_small;
        n_has      = r_has;
        n_cnt      = r_cnt;
        if (nz) begin
            if (!r_has || i_amount < r_small) begin
                n_small = i_amount;
            end
            n_has = 1'b1;
            n_cnt = r_cnt + CNT_W'(1);
        end
        n_entry = r_entry + EW'(1);

        // Metric of the row including the current item
        case (i_heuristic)
            dvs_pkg::HEUR_MAX_LARGEST: begin
                o_metric = $signed({{(MW-AMOUNT_WIDTH){1'b0}}, n_largest});
            end
            dvs_pkg::HEUR_MIN_SMALLEST: begin
                o_metric = n_has ? $signed({{(MW-AMOUNT_WIDTH){1'b0}}, n_small}) : '1;
            end
            dvs_pkg::HEUR_MAX_COUNT, dvs_pkg::HEUR_MIN_COUNT: begin
                o_metric = $signed({{(MW-CNT_W){1'b0}}, n_cnt});
            end
            default: begin
                o_metric = $signed({1'b0, n_sum});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry   <= '0;
            r_sum     <= '0;
            r_largest <= '0;
            r_small   <= '0;
            r_has     <= 1'b0;
            r_cnt     <= '0;
        end else if (i_accept) begin
            if (o_row_last) begin
                r_entry   <= '0;
                r_sum     <= '0;
                r_largest <= '0;
                r_small   <= '0;
                r_has     <= 1'b0;
                r_cnt     <= '0;
            end else begin
                r_entry   <= n_entry;
                r_sum     <= n_sum;
                r_largest <= n_largest;
                r_small   <= n_small;
                r_has     <= n_has;
                r_cnt     <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

/* src/deadlock_victim_selector.sv */
// Deadlock victim selector.
// Channels: i_in carries one allocation matrix entry per item (alloc_amount and
// thread_deadlocked), rows in thread order, resources_in_use entries per row and
// threads_in_use rows per selection. o_out carries one result per selection:
// victim_index, victim_found and victim_metric. i_cfg writes heuristic (index 0),
// threads_in_use (1) and resources_in_use (2); it is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// Throughput: one item per cycle while i_in.ready is high. Each entry passes
// through one add, the compares and the metric select into the row registers, and
// the last entry of a row also through the best-thread compare in the same cycle.
// Latency: the result is valid in the cycle after the last entry of the last row
// is accepted, held in the output register.
// Stall: while a result waits in the output register and o_out.ready is low,
// i_in.ready is low; with o_out.ready high a new item is taken in the same cycle
// the result leaves.
// Reset: synchronous, active low; clears all positions and running values and
// sets heuristic 0, threads_in_use 64 and resources_in_use 16.
`default_nettype none

module deadlock_victim_selector #(
    parameter int MAX_THREADS   = dvs_pkg::DEF_MAX_THREADS,
    parameter int RES_LIMIT     = dvs_pkg::DEF_RES_LIMIT,
    parameter int AMOUNT_WIDTH  = dvs_pkg::DEF_AMOUNT_WIDTH
) (
    input wire       i_clk,
    input wire       i_rst_n,
    dvs_in_if.sink   i_in,
    dvs_out_if.source o_out,
    dvs_cfg_if.sink  i_cfg
);

    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int MW = AMOUNT_WIDTH + $clog2(RES_LIMIT) + 1;

    logic [dvs_pkg::HEUR_W-1:0]    r_heuristic;
    logic [dvs_pkg::THR_CFG_W-1:0] r_threads;
    logic [dvs_pkg::RES_CFG_W-1:0] r_resources;

    logic [TW-1:0]        r_thread;
    logic [TW-1:0]        r_best_thread, n_best_thread;
    logic signed [MW-1:0] r_best_value, n_best_value;
    logic                 r_have_best, n_have_best;

    logic                 r_out_valid;
    logic [TW-1:0]        r_out_index;
    logic                 r_out_found;
    logic signed [MW-1:0] r_out_metric;

    logic                 accept;
    logic                 row_last;
    logic                 sel_last;
    logic                 final_accept;
    logic                 better;
    logic signed [MW-1:0] metric;
    logic [31:0]          nthr;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heuristic <= dvs_pkg::HEUR_RESET;
            r_threads   <= dvs_pkg::THR_CFG_RESET;
            r_resources <= dvs_pkg::RES_CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dvs_pkg::CFG_HEURISTIC: begin
                    r_heuristic <= i_cfg.data[dvs_pkg::HEUR_W-1:0];
                end
                dvs_pkg::CFG_THREADS_IN_USE: begin
                    r_threads <= i_cfg.data[dvs_pkg::THR_CFG_W-1:0];
                end
                dvs_pkg::CFG_RESOURCES_IN_USE: begin
                    r_resources <= i_cfg.data[dvs_pkg::RES_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input handshake: blocked only by a result still waiting
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    dvs_row_acc #(
        .RES_LIMIT     (RES_LIMIT),
        .AMOUNT_WIDTH  (AMOUNT_WIDTH)
    ) u_row_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_amount    (i_in.alloc_amount),
        .i_heuristic (r_heuristic),
        .i_res_count (r_resources),
        .o_row_last  (row_last),
        .o_metric    (metric)
    );

    assign nthr         = dvs_pkg::clamp_count(32'(r_threads), 32'(MAX_THREADS));
    assign sel_last     = row_last && (32'(r_thread) + 32'd1 >= nthr);
    assign final_accept = accept && sel_last;

    always_comb begin
        if (!r_have_best) begin
            better = 1'b1;
        end else if (dvs_pkg::want_max(r_heuristic)) begin
            better = metric > r_best_value;
        end else begin
            better = metric < r_best_value;
        end
        n_best_thread = r_best_thread;
        n_best_value  = r_best_value;
        n_have_best   = r_have_best;
        if (row_last && i_in.thread_deadlocked && better) begin
            n_best_thread = r_thread;
            n_best_value  = metric;
            n_have_best   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thread      <= '0;
            r_best_thread <= '0;
            r_best_value  <= '0;
            r_have_best   <= 1'b0;
        end else if (accept) begin
            if (sel_last) begin
                r_thread      <= '0;
                r_best_thread <= '0;
                r_best_value  <= '0;
                r_have_best   <= 1'b0;
            end else begin
                if (row_last) begin
                    r_thread <= r_thread + TW'(1);
                end
                r_best_thread <= n_best_thread;
                r_best_value  <= n_best_value;
                r_have_best   <= n_have_best;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (final_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (final_accept) begin
            r_out_index  <= n_have_best ? n_best_thread : '0;
            r_out_found  <= n_have_best;
            r_out_metric <= n_have_best ? n_best_value : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.victim_index  = r_out_index;
    assign o_out.victim_found  = r_out_found;
    assign o_out.victim_metric = r_out_metric;

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.victim_found |-> o_out.victim_index == '0 && o_out.victim_metric == '0)
        else $error("empty selection reported non-zero index or metric");

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        final_accept |=> r_out_valid && r_thread == '0 && !r_have_best)
        else $error("selection end did not present a result and restart");

    a_best_cleared_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_have_best) && $past(i_rst_n) |-> $past(final_accept))
        else $error("best thread dropped outside a selection end");

endmodule

`default_nettype wire
